[hdl/tlbl_pkg.sv]
`default_nettype none

package tlbl_pkg;

	// Defaults for the top-level parameters
	localparam int TLB_ENTRIES_DEF = 8;
	localparam int TABLE_PAGES_DEF = 8;

	// Fixed field widths
	localparam int PAGE_BITS    = 16;
	localparam int FRAME_BITS   = 8;
	localparam int CNT_W        = 32;

	// Page table registers: bit 8 valid, bits 7..0 frame
	localparam int PT_REGS      = 8;
	localparam int PT_IDX_W     = 3;
	localparam int PT_W         = 9;
	localparam int PT_VALID_BIT = 8;
	localparam int CFG_IDX_W    = 4;

	// Request modes
	localparam logic MODE_XLATE = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	typedef logic [PT_W-1:0] pt_word_t;

	typedef struct packed {
		logic                 mode;
		logic [PAGE_BITS-1:0] page;
	} req_t;

	typedef struct packed {
		logic [FRAME_BITS-1:0] frame;
		logic                  tlb_hit;
		logic                  page_fault;
		logic [CNT_W-1:0]      hit_total;
		logic [CNT_W-1:0]      miss_total;
	} res_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic look;
		logic upd;
	} cmd_t;

	function automatic pt_word_t pt_reset_val(input logic [PT_IDX_W-1:0] idx);
		pt_word_t v;
		unique case (idx)
			3'd0: v = 9'd261;
			3'd1: v = 9'd258;
			3'd2: v = 9'd264;
			3'd3: v = 9'd257;
			3'd4: v = 9'd265;
			3'd5: v = 9'd259;
			3'd6: v = 9'd263;
			3'd7: v = 9'd260;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

[hdl/tlbl_ctrl.sv]
`default_nettype none

module tlbl_ctrl
	import tlbl_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  start,
	output logic busy,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_UPD
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOOK;
						busy_q  <= 1'b1;
					end
				end
				ST_LOOK: begin
					state_q <= ST_UPD;
					busy_q  <= 1'b1;
				end
				ST_UPD: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy     = busy_q;
	assign cmd.load = start && !busy_q;
	assign cmd.look = (state_q == ST_LOOK);
	assign cmd.upd  = (state_q == ST_UPD);

endmodule

`default_nettype wire

[hdl/tlbl_dp.sv]
`default_nettype none

module tlbl_dp
	import tlbl_pkg::*;
#(
	parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
	parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  cmd_t                 cmd,
	input  req_t                 req,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_idx,
	input  wire [PT_W-1:0]       cfg_data,
	output logic                 done,
	output res_t                 res
);

	localparam int IDX_W = $clog2(TLB_ENTRIES);
	localparam int AGE_W = IDX_W;

	// Captured request and page table
	req_t     req_q;
	pt_word_t pt_q [PT_REGS];

	// TLB entries
	logic [TLB_ENTRIES-1:0] vld_q;
	logic [PAGE_BITS-1:0]   pg_q  [TLB_ENTRIES];
	logic [FRAME_BITS-1:0]  frm_q [TLB_ENTRIES];
	logic [AGE_W-1:0]       age_q [TLB_ENTRIES];
	logic [AGE_W-1:0]       age_d [TLB_ENTRIES];

	logic [CNT_W-1:0] hit_cnt_q, miss_cnt_q, hit_cnt_d, miss_cnt_d;

	// Lookup results
	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [AGE_W-1:0]      hit_age_q;
	logic [FRAME_BITS-1:0] hit_frm_q;
	logic [IDX_W-1:0]      slot_q;
	logic                  pt_ok_q;
	logic [FRAME_BITS-1:0] pt_frm_q;

	logic [TLB_ENTRIES-1:0] match_vec, victim_vec;
	logic [IDX_W-1:0]       hit_idx, free_idx, victim_idx, slot;
	pt_word_t               pt_sel;
	logic                   in_tbl;

	res_t res_d, res_q;
	logic done_q;
	logic upd_xlate, upd_hit, upd_fill;

	// Parallel tag compare, LRU victim is the valid entry of the oldest age
	always_comb begin
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			match_vec[i]  = vld_q[i] && (pg_q[i] == req_q.page);
			victim_vec[i] = vld_q[i] && (age_q[i] == AGE_W'(TLB_ENTRIES - 1));
		end
	end

	always_comb begin
		hit_idx    = '0;
		free_idx   = '0;
		victim_idx = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			if (match_vec[i])  hit_idx    = IDX_W'(i);
			if (!vld_q[i])     free_idx   = IDX_W'(i);
			if (victim_vec[i]) victim_idx = IDX_W'(i);
		end
	end

	assign slot   = (&vld_q) ? victim_idx : free_idx;
	assign pt_sel = pt_q[req_q.page[PT_IDX_W-1:0]];
	assign in_tbl = (req_q.page < PAGE_BITS'(TABLE_PAGES));

	// Page table registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PT_REGS; i++) begin
				pt_q[i] <= pt_reset_val(PT_IDX_W'(i));
			end
		end else if (cfg_we && (cfg_idx < CFG_IDX_W'(PT_REGS))) begin
			pt_q[cfg_idx[PT_IDX_W-1:0]] <= cfg_data;
		end
	end

	// Request capture and lookup registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.look) begin
			hit_q     <= |match_vec;
			hit_idx_q <= hit_idx;
			hit_age_q <= age_q[hit_idx];
			hit_frm_q <= frm_q[hit_idx];
			slot_q    <= slot;
			pt_ok_q   <= in_tbl && pt_sel[PT_VALID_BIT];
			pt_frm_q  <= pt_sel[FRAME_BITS-1:0];
		end
	end

	assign upd_xlate = cmd.upd && (req_q.mode == MODE_XLATE);
	assign upd_hit   = upd_xlate && hit_q;
	assign upd_fill  = upd_xlate && !hit_q && pt_ok_q;

	// LRU ages: touched entry to zero, younger valid ones one older
	always_comb begin
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			age_d[i] = age_q[i];
			if (upd_hit) begin
				if (hit_idx_q == IDX_W'(i)) begin
					age_d[i] = '0;
				end else if (vld_q[i] && (age_q[i] < hit_age_q)) begin
					age_d[i] = age_q[i] + AGE_W'(1);
				end
			end else if (upd_fill) begin
				if (slot_q == IDX_W'(i)) begin
					age_d[i] = '0;
				end else if (vld_q[i]) begin
					age_d[i] = age_q[i] + AGE_W'(1);
				end
			end
		end
	end

	// Saturating counters and result
	always_comb begin
		hit_cnt_d  = hit_cnt_q;
		miss_cnt_d = miss_cnt_q;
		res_d      = '0;
		if (req_q.mode == MODE_CLEAR) begin
			hit_cnt_d  = '0;
			miss_cnt_d = '0;
		end else if (hit_q) begin
			if (hit_cnt_q != '1) hit_cnt_d = hit_cnt_q + CNT_W'(1);
			res_d.frame   = hit_frm_q;
			res_d.tlb_hit = 1'b1;
		end else begin
			if (miss_cnt_q != '1) miss_cnt_d = miss_cnt_q + CNT_W'(1);
			if (pt_ok_q) begin
				res_d.frame = pt_frm_q;
			end else begin
				res_d.page_fault = 1'b1;
			end
		end
		res_d.hit_total  = hit_cnt_d;
		res_d.miss_total = miss_cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			done_q     <= 1'b0;
			for (int i = 0; i < TLB_ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else begin
			done_q <= cmd.upd;
			if (cmd.upd) begin
				hit_cnt_q  <= hit_cnt_d;
				miss_cnt_q <= miss_cnt_d;
			end
			if (upd_fill) begin
				vld_q[slot_q] <= 1'b1;
			end
			for (int i = 0; i < TLB_ENTRIES; i++) begin
				age_q[i] <= age_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fill) begin
			pg_q[slot_q]  <= req_q.page;
			frm_q[slot_q] <= pt_frm_q;
		end
		if (cmd.upd) begin
			res_q <= res_d;
		end
	end

	assign done = done_q;
	assign res  = res_q;

	// A full TLB holds a permutation of ages: exactly one oldest entry
	a_lru_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q) |-> $onehot(victim_vec))
		else $error("LRU ages not a permutation");

	// A hit never changes which entries are valid
	a_hit_keeps_valid: assert property (@(posedge clk) disable iff (!arst_n)
		upd_hit |=> (vld_q == $past(vld_q)))
		else $error("valid bits changed on a hit");

endmodule

`default_nettype wire

[hdl/tlb_lru_translate.sv]
// Channel  Ports                          Handshake
// -------  -----------------------------  -------------------------------------
// request  start, busy, req (req_t)       taken at an edge with start & !busy
// result   done, res (res_t)              one-cycle strobe, cannot be held off
// config   cfg_we, cfg_idx, cfg_data      page table word, cfg_we & cfg_idx < 8
//
// A request goes through capture, tag lookup and update. The result strobe
// comes in the cycle after the update, and busy is already low in that cycle,
// so the next request can be taken while the result is shown, and none is
// taken earlier. The controller's lookup/update sequence sets the pace.
// Reset clears the TLB valid bits, ages and counters and reloads the page
// table words; no clearing pass is needed. The receiver cannot stall.
`default_nettype none

module tlb_lru_translate
	import tlbl_pkg::*;
#(
	parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
	parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	// request
	input  wire                 start,
	output logic                busy,
	input  req_t                req,
	// result
	output logic                done,
	output res_t                res,
	// page table writes
	input  wire                 cfg_we,
	input  wire [CFG_IDX_W-1:0] cfg_idx,
	input  wire [PT_W-1:0]      cfg_data
);

	cmd_t cmd;

	// Sequencer: idle, lookup, update
	tlbl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Entry array, LRU ages, page table and counters
	tlbl_dp #(
		.TLB_ENTRIES (TLB_ENTRIES),
		.TABLE_PAGES (TABLE_PAGES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.done     (done),
		.res      (res)
	);

	// An accepted request makes the block busy straight away
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after request");

	// A hit and a page fault never come together; a fault returns frame zero
	a_hit_fault_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(res.tlb_hit && res.page_fault))
		else $error("hit and page fault both set");

	a_fault_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.page_fault) |-> (res.frame == '0))
		else $error("page fault with non-zero frame");

endmodule

`default_nettype wire
